@@ rtl/core/lacl_pkg.sv @@
// Shared types, register indexes, reset values and constant-divide helpers
// for the latency adaptive concurrency limiter. No dependencies.
package lacl_pkg;

    localparam int CountWidthDefault = 32;
    localparam int CfgIndexWidth     = 2;
    localparam int CfgDataWidth      = 32;
    localparam int LatWidth          = 32;
    localparam int ConcWidth         = 16;

    localparam logic [LatWidth-1:0]  ThresholdReset = 32'd100;
    localparam logic [ConcWidth-1:0] WindowReset    = 16'd10;
    localparam logic [ConcWidth-1:0] MaxConcReset   = 16'd64;

    // Register indexes of the configuration port
    typedef enum logic [CfgIndexWidth-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_WINDOW    = 2'd1,
        REG_MAX_CONC  = 2'd2
    } t_cfg_reg;

    // Input command codes
    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_TICK   = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [LatWidth-1:0]  threshold;
        logic [ConcWidth-1:0] window;
        logic [ConcWidth-1:0] max_conc;
    } t_cfg;

    // Limit reload: a limit of zero acts as one
    typedef struct packed {
        logic                 load;
        logic [ConcWidth-1:0] value;
    } t_reload;

    // floor(c/3) as c*43691 >> 17, exact for every 16-bit c
    function automatic logic [ConcWidth-1:0] div3(input logic [ConcWidth-1:0] c);
        logic [31:0] prod;
        prod = 32'(c) * 32'd43691;
        return {1'b0, prod[31:17]};
    endfunction

    // floor(c*13/10) as c*87241531 >> 26, exact for every 16-bit c
    function automatic logic [16:0] mul13div10(input logic [ConcWidth-1:0] c);
        logic [42:0] prod;
        prod = 43'(c) * 43'd87241531;
        return prod[42:26];
    endfunction

endpackage

@@ rtl/core/lacl_cfg_regs.sv @@
// Configuration register file of the concurrency limiter.
// Depends on lacl_pkg for the register indexes and reset values.
module lacl_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [lacl_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  logic [lacl_pkg::CfgDataWidth-1:0]  i_cfg_data,
    output lacl_pkg::t_cfg                   o_cfg,
    output lacl_pkg::t_reload                o_reload
);
    import lacl_pkg::*;

    t_cfg r_cfg;
    logic w_max_wr;

    assign w_max_wr = i_cfg_valid && (i_cfg_index == REG_MAX_CONC);

    // Capture register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= ThresholdReset;
            r_cfg.window    <= WindowReset;
            r_cfg.max_conc  <= MaxConcReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_THRESHOLD: r_cfg.threshold <= i_cfg_data;
                REG_WINDOW:    r_cfg.window    <= i_cfg_data[ConcWidth-1:0];
                REG_MAX_CONC:  r_cfg.max_conc  <= i_cfg_data[ConcWidth-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

    // Reload concurrency with the new limit, zero treated as one
    always_comb begin
        o_reload.load  = w_max_wr;
        o_reload.value = (i_cfg_data[ConcWidth-1:0] == '0) ? ConcWidth'(1)
                                                           : i_cfg_data[ConcWidth-1:0];
    end

endmodule

@@ rtl/core/lacl_datapath.sv @@
// Sample counters, stable phase and concurrency decision of the limiter.
// Depends on lacl_pkg for types and the constant-divide helpers.
module lacl_datapath #(
    parameter int COUNT_WIDTH = lacl_pkg::CountWidthDefault
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lacl_pkg::t_cfg                  i_cfg,
    input  lacl_pkg::t_reload               i_reload,
    input  logic                            i_step,
    input  logic                            i_cmd,
    input  logic [lacl_pkg::LatWidth-1:0]   i_latency,
    output logic [lacl_pkg::ConcWidth-1:0]  o_concurrency,
    output logic                            o_updated
);
    import lacl_pkg::*;

    localparam int ProdWidth = COUNT_WIDTH + 7;
    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

    logic [COUNT_WIDTH-1:0] r_good, n_good;
    logic [COUNT_WIDTH-1:0] r_total, n_total;
    logic [ConcWidth-1:0]   r_phase, n_phase;
    logic [ConcWidth-1:0]   r_conc, n_conc;

    logic [ProdWidth-1:0] w_good100, w_total99;
    logic [ConcWidth:0]   w_phase_inc;
    logic [ConcWidth-1:0] w_lower, w_lim;
    logic [ConcWidth:0]   w_raise;
    logic                 w_bad, w_tick, w_good_lat;

    // Scale both counters for the 99 percent check
    assign w_good100 = (ProdWidth'(r_good) << 6) + (ProdWidth'(r_good) << 5)
                     + (ProdWidth'(r_good) << 2);
    assign w_total99 = (ProdWidth'(r_total) << 7) - (ProdWidth'(r_total) << 5)
                     + (ProdWidth'(r_total) << 2) - ProdWidth'(r_total);
    assign w_bad     = w_good100 < w_total99;

    assign w_tick      = i_step && (i_cmd == CMD_TICK);
    assign w_good_lat  = i_latency <= i_cfg.threshold;
    assign w_phase_inc = {1'b0, r_phase} + 17'd1;
    assign w_lower     = (div3(r_conc) == '0) ? ConcWidth'(1) : div3(r_conc);
    assign w_raise     = mul13div10(r_conc);
    assign w_lim       = (i_cfg.max_conc == '0) ? ConcWidth'(1) : i_cfg.max_conc;

    // Next state: count samples, decide on ticks, apply limit reloads
    always_comb begin
        n_good    = r_good;
        n_total   = r_total;
        n_phase   = r_phase;
        n_conc    = r_conc;
        o_updated = 1'b0;
        if (i_step && (i_cmd == CMD_SAMPLE)) begin
            if (r_total != CountMax) n_total = r_total + 1'b1;
            if (w_good_lat && (r_good != CountMax)) n_good = r_good + 1'b1;
        end else if (w_tick) begin
            n_good  = '0;
            n_total = '0;
            if (w_bad) begin
                n_conc    = w_lower;
                n_phase   = '0;
                o_updated = 1'b1;
            end else if (w_phase_inc >= {1'b0, i_cfg.window}) begin
                n_conc    = (w_raise > {1'b0, w_lim}) ? w_lim : w_raise[ConcWidth-1:0];
                n_phase   = '0;
                o_updated = 1'b1;
            end else begin
                n_phase = w_phase_inc[ConcWidth-1:0];
            end
        end
        if (i_reload.load) n_conc = i_reload.value;
    end

    assign o_concurrency = n_conc;

    // Hold the limiter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_good  <= '0;
            r_total <= '0;
            r_phase <= '0;
            r_conc  <= MaxConcReset;
        end else begin
            r_good  <= n_good;
            r_total <= n_total;
            r_phase <= n_phase;
            r_conc  <= n_conc;
        end
    end

endmodule

@@ rtl/core/latency_adaptive_concurrency_limiter_top.sv @@
// Top level of the latency adaptive concurrency limiter: input and result
// registers around lacl_datapath and lacl_cfg_regs. Depends on lacl_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall, i_cmd, i_latency): each transfer is
//   a latency sample (CMD_SAMPLE) or a tick (CMD_TICK). Samples give no
//   result; each tick gives one result (o_concurrency, o_updated) on the
//   output channel (o_out_valid / i_out_stall).
//   Throughput: one item per cycle unless the input stalls. Every item passes
//   the input register and then the state update; a tick's result is then
//   loaded into the result register together with the new state.
//   The config channel (i_cfg_valid / o_cfg_ready) is always ready; write
//   only while the block is idle. Writing max_concurrency reloads
//   concurrency with the new limit (zero acts as one).
//   Reset (synchronous, active low) restores threshold 100, window 10,
//   limit and concurrency 64, clears counters and empties both registers.
//   When the receiver stalls, the result register holds; samples behind it
//   keep flowing, and a tick waiting in the input register stalls the input.
module latency_adaptive_concurrency_limiter_top #(
    parameter int COUNT_WIDTH = lacl_pkg::CountWidthDefault
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_cmd,
    input  logic [lacl_pkg::LatWidth-1:0]      i_latency,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [lacl_pkg::ConcWidth-1:0]     o_concurrency,
    output logic                               o_updated,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lacl_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  logic [lacl_pkg::CfgDataWidth-1:0]  i_cfg_data
);
    import lacl_pkg::*;

    t_cfg    w_cfg;
    t_reload w_reload;

    logic                 r_s1_valid;
    logic                 r_s1_cmd;
    logic [LatWidth-1:0]  r_s1_latency;
    logic                 r_out_valid;
    logic [ConcWidth-1:0] r_out_conc;
    logic                 r_out_upd;
    logic                 w_s1_go, w_in_xfer, w_out_load;
    logic [ConcWidth-1:0] w_conc;
    logic                 w_upd;

    assign o_cfg_ready = 1'b1;

    // A sample always drains; a tick needs the result register free
    assign w_s1_go    = r_s1_valid && ((r_s1_cmd == CMD_SAMPLE) || !r_out_valid
                                       || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_s1_go;
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_load = w_s1_go && (r_s1_cmd == CMD_TICK);

    lacl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .o_reload    (w_reload)
    );

    lacl_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_reload      (w_reload),
        .i_step        (w_s1_go),
        .i_cmd         (r_s1_cmd),
        .i_latency     (r_s1_latency),
        .o_concurrency (w_conc),
        .o_updated     (w_upd)
    );

    // Input register: advance on transfer, drop when drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_cmd     <= i_cmd;
            r_s1_latency <= i_latency;
        end
    end

    // Result register: load on tick, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_conc <= w_conc;
            r_out_upd  <= w_upd;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_concurrency = r_out_conc;
    assign o_updated     = r_out_upd;

endmodule
